[hdl/mlcs_pkg.sv]
package mlcs_pkg;

  // command codes
  localparam logic CMD_ADD     = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  typedef logic [1:0] status_t;

  // result status codes
  localparam status_t ST_ADDED   = 2'd0;
  localparam status_t ST_DROPPED = 2'd1;
  localparam status_t ST_GRANTED = 2'd2;
  localparam status_t ST_EMPTY   = 2'd3;

  localparam int ID_W  = 8;
  localparam int LVL_FIELD_W = 3;

  typedef logic [ID_W-1:0]        pid_t;
  typedef logic [LVL_FIELD_W-1:0] lvl_field_t;

  // decision handed from the level controller to the datapath
  typedef struct packed {
    logic    wr_en;   // push id into the store
    logic    rd_en;   // pop id from the store
    status_t status;
  } mlcs_dec_t;

endpackage

[hdl/mlcs_store.sv]
module mlcs_store #(
  parameter int ADDR_W = 7
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  mlcs_pkg::pid_t       wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output mlcs_pkg::pid_t       rd_data
);
  import mlcs_pkg::*;

  localparam int DEPTH = 2 ** ADDR_W;

  pid_t mem [DEPTH];
  pid_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/mlcs_level_ctrl.sv]
module mlcs_level_ctrl #(
  parameter int NUM_LEVELS  = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int LVL_W       = 3,
  parameter int PTR_W       = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    item_vld,
  input  logic                    cmd,
  input  mlcs_pkg::lvl_field_t    add_level,
  output mlcs_pkg::mlcs_dec_t     dec,
  output logic [LVL_W-1:0]        lvl,
  output logic [PTR_W-1:0]        slot
);
  import mlcs_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CRD_W = $clog2(NUM_LEVELS + 1);

  logic [PTR_W-1:0] head_r   [NUM_LEVELS];
  logic [PTR_W-1:0] tail_r   [NUM_LEVELS];
  logic [CNT_W-1:0] count_r  [NUM_LEVELS];
  logic [CRD_W-1:0] credit_r [NUM_LEVELS];
  logic [PTR_W-1:0] head_nxt   [NUM_LEVELS];
  logic [PTR_W-1:0] tail_nxt   [NUM_LEVELS];
  logic [CNT_W-1:0] count_nxt  [NUM_LEVELS];
  logic [CRD_W-1:0] credit_nxt [NUM_LEVELS];

  logic             in_range;
  logic [LVL_W-1:0] add_idx;
  logic             add_full;
  logic             found_cr;
  logic [LVL_W-1:0] sel_cr;
  logic             found_any;
  logic [LVL_W-1:0] sel_any;
  logic             grant;
  logic [LVL_W-1:0] sel;
  logic             do_push;
  logic             do_pop;
  logic             refill;

  function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
    else                              r = p + 1'b1;
    return r;
  endfunction

  // add path: range and full check
  assign in_range = (int'(add_level) < NUM_LEVELS);
  assign add_idx  = LVL_W'(add_level);
  assign add_full = in_range && (count_r[add_idx] == CNT_W'(QUEUE_DEPTH));

  // request path: two fixed-priority encoders, with and without credit
  always_comb begin
    found_cr  = 1'b0;
    sel_cr    = '0;
    found_any = 1'b0;
    sel_any   = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (count_r[i] != '0 && credit_r[i] != '0) begin
        found_cr = 1'b1;
        sel_cr   = LVL_W'(i);
      end
      if (count_r[i] != '0) begin
        found_any = 1'b1;
        sel_any   = LVL_W'(i);
      end
    end
  end

  assign grant   = found_cr || found_any;
  assign sel     = found_cr ? sel_cr : sel_any;
  assign refill  = item_vld && (cmd == CMD_REQUEST) && !found_cr;
  assign do_push = item_vld && (cmd == CMD_ADD) && in_range && !add_full;
  assign do_pop  = item_vld && (cmd == CMD_REQUEST) && grant;

  // decision and store address
  always_comb begin
    dec.wr_en = do_push;
    dec.rd_en = do_pop;
    if (cmd == CMD_ADD) begin
      dec.status = (in_range && !add_full) ? ST_ADDED : ST_DROPPED;
      lvl        = add_idx;
      slot       = in_range ? tail_r[add_idx] : '0;
    end else begin
      dec.status = grant ? ST_GRANTED : ST_EMPTY;
      lvl        = sel;
      slot       = head_r[sel];
    end
  end

  // per-level next state
  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      head_nxt[i]   = head_r[i];
      tail_nxt[i]   = tail_r[i];
      count_nxt[i]  = count_r[i];
      credit_nxt[i] = refill ? CRD_W'(NUM_LEVELS - i) : credit_r[i];
      if (do_push && add_idx == LVL_W'(i)) begin
        tail_nxt[i]  = wrap_next(tail_r[i]);
        count_nxt[i] = count_r[i] + 1'b1;
      end
      if (do_pop && sel == LVL_W'(i)) begin
        head_nxt[i]   = wrap_next(head_r[i]);
        count_nxt[i]  = count_r[i] - 1'b1;
        credit_nxt[i] = refill ? CRD_W'(NUM_LEVELS - i - 1) : credit_r[i] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i]   <= '0;
        tail_r[i]   <= '0;
        count_r[i]  <= '0;
        credit_r[i] <= CRD_W'(NUM_LEVELS - i);
      end
    end else if (item_vld) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i]   <= head_nxt[i];
        tail_r[i]   <= tail_nxt[i];
        count_r[i]  <= count_nxt[i];
        credit_r[i] <= credit_nxt[i];
      end
    end
  end

endmodule

[hdl/multilevel_credit_scheduler_core.sv]
// Multilevel credit scheduler: one FIFO of process ids per priority level,
// level 0 most urgent, and one credit counter per level (level i starts at
// NUM_LEVELS - i). An add word appends in_process_id to its level's FIFO or
// is dropped when that FIFO is full or the level is out of range. A request
// word grants the head of the most urgent nonempty level with credit left;
// when none has credit, all credits refill and the most urgent nonempty
// level is granted.
// Input channel: a word is taken at a clock edge with start high and busy
// low. busy is always low: one word is taken every cycle.
// Result channel: out_valid comes from the result register, which follows the
// input register, and stays high for one cycle; the result is taken while
// out_valid is high; results keep input order. The receiver cannot stall.
// Pipeline: input register, then level selection and the store access
// (one write or one registered read of the id store), then result register.
// Reset (rst_n low, synchronous) empties all FIFOs and restores all
// credits; the id store itself is not cleared and needs no sweep.
module multilevel_credit_scheduler_core #(
  parameter int NUM_LEVELS  = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_cmd,
  input  mlcs_pkg::pid_t       in_process_id,
  input  mlcs_pkg::lvl_field_t in_process_level,
  output logic                 out_valid,
  output mlcs_pkg::status_t    out_status,
  output mlcs_pkg::pid_t       out_granted_id,
  output mlcs_pkg::lvl_field_t out_granted_level
);
  import mlcs_pkg::*;

  localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W = LVL_W + PTR_W;

  logic       in_vld_r;
  logic       in_cmd_r;
  pid_t       in_id_r;
  lvl_field_t in_lvl_r;

  mlcs_dec_t        dec;
  logic [LVL_W-1:0] lvl;
  logic [PTR_W-1:0] slot;
  pid_t             rd_data;

  logic       out_vld_r;
  status_t    status_r;
  lvl_field_t glvl_r;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_cmd_r <= in_cmd;
      in_id_r  <= in_process_id;
      in_lvl_r <= in_process_level;
    end
  end

  // level bookkeeping and selection
  mlcs_level_ctrl #(
    .NUM_LEVELS  (NUM_LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LVL_W       (LVL_W),
    .PTR_W       (PTR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (in_vld_r),
    .cmd       (in_cmd_r),
    .add_level (in_lvl_r),
    .dec       (dec),
    .lvl       (lvl),
    .slot      (slot)
  );

  // id store, addressed by level and slot
  mlcs_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (dec.wr_en),
    .wr_addr ({lvl, slot}),
    .wr_data (in_id_r),
    .rd_en   (dec.rd_en),
    .rd_addr ({lvl, slot}),
    .rd_data (rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      status_r <= dec.status;
      glvl_r   <= (dec.status == ST_GRANTED) ? LVL_FIELD_W'(lvl) : '0;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_status        = status_r;
  assign out_granted_level = glvl_r;
  assign out_granted_id    = (status_r == ST_GRANTED) ? rd_data : '0;

endmodule
